FILE: hdl/acache_pkg.sv
// Shared types and constants for the ARP cache engine.
// No dependencies; imported by the engine top level, both checkers and the bench top.
package acache_pkg;

    // Result status codes
    localparam logic [2:0] ST_DROPPED     = 3'd0;
    localparam logic [2:0] ST_LEARNED     = 3'd1;
    localparam logic [2:0] ST_LEARN_REPLY = 3'd2;
    localparam logic [2:0] ST_BROADCAST   = 3'd3;
    localparam logic [2:0] ST_HIT         = 3'd4;
    localparam logic [2:0] ST_MISS        = 3'd5;

    // Request modes
    localparam logic MODE_RX_HEADER = 1'b0;
    localparam logic MODE_RESOLVE   = 1'b1;

    // Configuration register indexes
    localparam logic REG_OWN_IP  = 1'b0;
    localparam logic REG_NETMASK = 1'b1;

    // ARP header constants
    localparam logic [15:0] HTYPE_ETH  = 16'h0001;
    localparam logic [15:0] PTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] OP_REQUEST = 16'h0001;

    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int ENTRY_W = IP_W + MAC_W;

    localparam logic [IP_W-1:0]  IP_ALL_ONES  = 32'hFFFF_FFFF;
    localparam logic [MAC_W-1:0] MAC_ALL_ONES = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

endpackage

FILE: hdl/acache_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module acache_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/arp_cache_engine_unit.sv
// ARP cache engine top level: IPv4-to-MAC binding table with sequential lookup.
// Depends on acache_pkg and acache_ram.
//
// Usage:
//   Request channel (req_valid / req_stall): mode 0 carries a received ARP header
//   to learn from, mode 1 carries an IP to resolve. Response channel
//   (rsp_valid / rsp_stall) returns exactly one result per request.
//   Config channel (cfg_valid / cfg_ready, always ready) writes own_ip (index 0)
//   and netmask (index 1); the user must write it only while idle (unenforced).
// Lookup:
//   Bindings sit in one RAM with registered read data; a lookup reads one
//   entry per cycle, in order, until the first match or the fill count.
//   An accepted request goes to a scan state, then to a final state that loads
//   the output register; a drop or broadcast answer skips the scan. The table
//   holds 32 entries by default. One request is in flight at a time;
//   req_stall is high while it is processed.
// Reset:
//   The fill count goes to zero, so every entry reads as invalid at once; no
//   clearing pass is needed. State goes to idle; control and config regs to zero.
// Stall:
//   The result register holds while rsp_stall is high; the next request may
//   be accepted and scanned meanwhile and waits in its final state to issue.
module arp_cache_engine_unit #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    // request
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        mode,
    input  logic        header_complete,
    input  logic [15:0] hw_type,
    input  logic [15:0] proto_type,
    input  logic [15:0] operation,
    input  logic [31:0] ip_address,
    input  logic [47:0] sender_mac,
    input  logic [31:0] target_addr,
    // response
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [2:0]  status,
    output logic [47:0] result_mac,
    output logic [31:0] result_ip
);
    import acache_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

    state_t state_reg, state_next;

    logic [IP_W-1:0] own_ip_reg, netmask_reg;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   scan_idx_reg, scan_idx_next;
    logic            rd_vld_reg, rd_vld_next;
    logic [AW-1:0]   rd_idx_reg;
    logic            rsp_valid_reg, rsp_valid_next;

    // held request
    logic              hold_mode_reg;
    logic [IP_W-1:0]   hold_ip_reg;
    logic [MAC_W-1:0]  hold_mac_reg;
    logic              hold_reply_reg;

    // pending result and output register
    logic [2:0]        res_status_reg, res_status_next;
    logic [MAC_W-1:0]  res_mac_reg, res_mac_next;
    logic [IP_W-1:0]   res_ip_reg, res_ip_next;
    logic [2:0]        out_status_reg;
    logic [MAC_W-1:0]  out_mac_reg;
    logic [IP_W-1:0]   out_ip_reg;

    logic               accept, hdr_ok, is_bcast, load_out;
    logic               issue, match, scan_end;
    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic [ENTRY_W-1:0] ram_rd_data;
    logic [IP_W-1:0]    bcast_ip;

    assign cfg_ready = 1'b1;
    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;

    assign hdr_ok   = header_complete && (hw_type == HTYPE_ETH) && (proto_type == PTYPE_IPV4);
    assign bcast_ip = own_ip_reg | ~netmask_reg;
    assign is_bcast = (ip_address == IP_ALL_ONES) || (ip_address == bcast_ip);

    assign issue    = (state_reg == S_SCAN) && (scan_idx_reg != count_reg) && !match;
    assign match    = rd_vld_reg && (ram_rd_data[ENTRY_W-1:MAC_W] == hold_ip_reg);
    assign scan_end = (state_reg == S_SCAN) && (match || (scan_idx_reg == count_reg));

    // learn: update the matching entry, else fill the next free slot, else entry 0
    assign ram_wr_en = scan_end && (hold_mode_reg == MODE_RX_HEADER);
    always_comb
    begin
        if (match)
        begin
            ram_wr_addr = rd_idx_reg;
        end
        else if (count_reg != FULL_COUNT)
        begin
            ram_wr_addr = count_reg[AW-1:0];
        end
        else
        begin
            ram_wr_addr = '0;
        end
    end

    acache_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_entry_ram (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data({hold_ip_reg, hold_mac_reg}),
        .rd_en  (issue),
        .rd_addr(scan_idx_reg[AW-1:0]),
        .rd_data(ram_rd_data)
    );

    assign load_out = (state_reg == S_DONE) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        rd_vld_next     = issue;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        res_status_next = res_status_reg;
        res_mac_next    = res_mac_reg;
        res_ip_next     = res_ip_reg;

        if (issue)
        begin
            scan_idx_next = scan_idx_reg + 1'b1;
        end
        if (load_out)
        begin
            rsp_valid_next = 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    scan_idx_next = '0;
                    res_ip_next   = ip_address;
                    res_mac_next  = '0;
                    if (mode == MODE_RX_HEADER && !hdr_ok)
                    begin
                        res_status_next = ST_DROPPED;
                        res_ip_next     = '0;
                        state_next      = S_DONE;
                    end
                    else if (mode == MODE_RESOLVE && is_bcast)
                    begin
                        res_status_next = ST_BROADCAST;
                        res_mac_next    = MAC_ALL_ONES;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = S_DONE;
                    if (hold_mode_reg == MODE_RX_HEADER)
                    begin
                        if (!match && count_reg != FULL_COUNT)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        res_status_next = hold_reply_reg ? ST_LEARN_REPLY : ST_LEARNED;
                        res_mac_next    = hold_reply_reg ? hold_mac_reg : '0;
                    end
                    else
                    begin
                        res_status_next = match ? ST_HIT : ST_MISS;
                        res_mac_next    = match ? ram_rd_data[MAC_W-1:0] : '0;
                    end
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            own_ip_reg    <= '0;
            netmask_reg   <= '0;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            rd_vld_reg    <= rd_vld_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_OWN_IP:  own_ip_reg  <= cfg_data;
                    REG_NETMASK: netmask_reg <= cfg_data;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_mode_reg  <= mode;
            hold_ip_reg    <= ip_address;
            hold_mac_reg   <= sender_mac;
            hold_reply_reg <= (operation == OP_REQUEST) && (target_addr == own_ip_reg);
        end
        if (issue)
        begin
            rd_idx_reg <= scan_idx_reg[AW-1:0];
        end
        res_status_reg <= res_status_next;
        res_mac_reg    <= res_mac_next;
        res_ip_reg     <= res_ip_next;
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_mac_reg    <= res_mac_reg;
            out_ip_reg     <= res_ip_reg;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign status     = out_status_reg;
    assign result_mac = out_mac_reg;
    assign result_ip  = out_ip_reg;

endmodule

FILE: hdl/acache_check.sv
// Port-level checker for the ARP cache engine, bound to the top level.
// Depends on acache_pkg and arp_cache_engine_unit.
module acache_check (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_stall,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic [2:0]  status,
    input logic [47:0] result_mac,
    input logic [31:0] result_ip
);
    import acache_pkg::*;

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(status)
            && $stable(result_mac) && $stable(result_ip))
        else $error("stalled response changed");

    // one request at a time: an accepted request makes the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request channel not stalled after accept");

    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_DROPPED |-> result_mac == '0 && result_ip == '0)
        else $error("dropped result carries data");

    a_bcast_ones: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_BROADCAST |-> result_mac == MAC_ALL_ONES)
        else $error("broadcast result not all ones");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_MISS || status == ST_LEARNED) |-> result_mac == '0)
        else $error("miss or plain learn carries a MAC");

endmodule

bind arp_cache_engine_unit acache_check u_acache_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .result_mac(result_mac),
    .result_ip (result_ip)
);

FILE: bench/acache_checker.sv
// Response checker for arp_cache_engine_unit: watches the config, request and response
// channels, keeps its own binding table and compares every response in order.
// Depends on acache_pkg.
module acache_checker #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        req_valid,
    input  logic        req_stall,
    input  logic        mode,
    input  logic        header_complete,
    input  logic [15:0] hw_type,
    input  logic [15:0] proto_type,
    input  logic [15:0] operation,
    input  logic [31:0] ip_address,
    input  logic [47:0] sender_mac,
    input  logic [31:0] target_addr,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  logic [2:0]  status,
    input  logic [47:0] result_mac,
    input  logic [31:0] result_ip,
    output int          mismatches,
    output int          outstanding
);
    import acache_pkg::*;

    typedef struct packed {
        logic [2:0]       status;
        logic [MAC_W-1:0] mac;
        logic [IP_W-1:0]  ip;
    } arp_answer_t;

    logic             bind_valid [TABLE_ENTRIES];
    logic [IP_W-1:0]  bind_ip    [TABLE_ENTRIES];
    logic [MAC_W-1:0] bind_mac   [TABLE_ENTRIES];
    logic [IP_W-1:0]  own_ip_reg;
    logic [IP_W-1:0]  mask_reg;
    arp_answer_t      answers_due [$];

    // Lowest valid entry holding this address, or -1.
    function automatic int find_binding(input logic [IP_W-1:0] ip);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (bind_valid[i] && bind_ip[i] == ip)
                return i;
        return -1;
    endfunction

    function automatic arp_answer_t predict_answer(
        input logic             md,
        input logic             complete,
        input logic [15:0]      htype,
        input logic [15:0]      ptype,
        input logic [15:0]      opcode,
        input logic [IP_W-1:0]  ip,
        input logic [MAC_W-1:0] mac,
        input logic [IP_W-1:0]  tip
    );
        arp_answer_t a;
        int          slot;
        logic [IP_W-1:0] subnet_bcast;
        a.status = ST_MISS;
        a.mac    = '0;
        a.ip     = ip;
        if (md == MODE_RX_HEADER)
        begin
            if (!complete || htype != HTYPE_ETH || ptype != PTYPE_IPV4)
            begin
                a.status = ST_DROPPED;
                a.ip     = '0;
            end
            else
            begin
                slot = find_binding(ip);
                if (slot < 0)
                begin
                    // first free slot; entry 0 when the table is full
                    slot = 0;
                    for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
                        if (!bind_valid[i])
                            slot = i;
                end
                bind_valid[slot] = 1'b1;
                bind_ip[slot]    = ip;
                bind_mac[slot]   = mac;
                if (opcode == OP_REQUEST && tip == own_ip_reg)
                begin
                    a.status = ST_LEARN_REPLY;
                    a.mac    = mac;
                end
                else
                    a.status = ST_LEARNED;
            end
        end
        else
        begin
            subnet_bcast = own_ip_reg | ~mask_reg;
            if (ip == IP_ALL_ONES || ip == subnet_bcast)
            begin
                a.status = ST_BROADCAST;
                a.mac    = MAC_ALL_ONES;
            end
            else
            begin
                slot = find_binding(ip);
                if (slot >= 0)
                begin
                    a.status = ST_HIT;
                    a.mac    = bind_mac[slot];
                end
            end
        end
        return a;
    endfunction

    task automatic check_field(input string label, input logic [MAC_W-1:0] want,
                               input logic [MAC_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t acache_checker: %s expected 0x%0h got 0x%0h", $time, label, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        arp_answer_t due;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                bind_valid[i] = 1'b0;
                bind_ip[i]    = '0;
                bind_mac[i]   = '0;
            end
            own_ip_reg = '0;
            mask_reg   = '0;
            answers_due.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_OWN_IP)
                    own_ip_reg = cfg_data;
                else
                    mask_reg = cfg_data;
            end
            if (req_valid && !req_stall)
                answers_due.push_back(predict_answer(mode, header_complete, hw_type, proto_type,
                                                     operation, ip_address, sender_mac,
                                                     target_addr));
            if (rsp_valid && !rsp_stall)
            begin
                if (answers_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t acache_checker: response with no request pending: status %0d",
                             $time, status);
                end
                else
                begin
                    due = answers_due.pop_front();
                    check_field("status", MAC_W'(due.status), MAC_W'(status));
                    check_field("result_mac", due.mac, result_mac);
                    check_field("result_ip", MAC_W'(due.ip), MAC_W'(result_ip));
                end
            end
            outstanding = answers_due.size();
        end
    end

endmodule

FILE: bench/tb_top.sv
// Top of the arp_cache_engine_unit bench: clock, reset, config writes, request
// stimulus in bursts and a stalling response side; acache_checker does the compare.
// Depends on acache_pkg, acache_checker and the engine RTL.
module tb_top;
    import acache_pkg::*;

    localparam int CYCLE_LIMIT      = 600000;
    localparam int PHASES           = 5;
    localparam int RANDOM_PER_PHASE = 256;
    localparam int POOL_SIZE        = 44;
    localparam int DRAIN_CYCLES     = 40;
    localparam int HOLD_OFF_CYCLES  = 400;
    localparam logic [15:0] OP_REPLY = 16'h0002;

    typedef struct packed {
        logic        mode;
        logic        complete;
        logic [15:0] htype;
        logic [15:0] ptype;
        logic [15:0] op;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [31:0] tip;
    } arp_req_t;

    typedef enum {FLOW_FREE, FLOW_HALF, FLOW_HEAVY, FLOW_LIGHT} rsp_flow_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;
    logic        req_valid;
    logic        req_stall;
    logic        mode;
    logic        header_complete;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [15:0] operation;
    logic [31:0] ip_address;
    logic [47:0] sender_mac;
    logic [31:0] target_addr;
    logic        rsp_valid;
    logic        rsp_stall;
    logic [2:0]  status;
    logic [47:0] result_mac;
    logic [31:0] result_ip;

    int          mismatches;
    int          outstanding;
    int          cycle_count = 0;
    int          burst_left  = 0;
    bit          squeeze_rsp = 1'b0;
    logic [31:0] own_ip_cfg;
    logic [31:0] mask_cfg;
    logic [31:0] ip_pool [POOL_SIZE];

    arp_cache_engine_unit #(.TABLE_ENTRIES(32)) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .mode            (mode),
        .header_complete (header_complete),
        .hw_type         (hw_type),
        .proto_type      (proto_type),
        .operation       (operation),
        .ip_address      (ip_address),
        .sender_mac      (sender_mac),
        .target_addr     (target_addr),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .status          (status),
        .result_mac      (result_mac),
        .result_ip       (result_ip)
    );

    acache_checker #(.TABLE_ENTRIES(32)) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .mode            (mode),
        .header_complete (header_complete),
        .hw_type         (hw_type),
        .proto_type      (proto_type),
        .operation       (operation),
        .ip_address      (ip_address),
        .sender_mac      (sender_mac),
        .target_addr     (target_addr),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .status          (status),
        .result_mac      (result_mac),
        .result_ip       (result_ip),
        .mismatches      (mismatches),
        .outstanding     (outstanding)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic arp_req_t make_request(
        input logic        md,
        input logic        complete,
        input logic [15:0] htype,
        input logic [15:0] ptype,
        input logic [15:0] op,
        input logic [31:0] ip,
        input logic [47:0] mac,
        input logic [31:0] tip
    );
        arp_req_t r;
        r.mode     = md;
        r.complete = complete;
        r.htype    = htype;
        r.ptype    = ptype;
        r.op       = op;
        r.ip       = ip;
        r.mac      = mac;
        r.tip      = tip;
        return r;
    endfunction

    // Mostly pool addresses so the table fills and lookups hit.
    function automatic logic [31:0] pick_ip();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (roll < 8)
            return $urandom;
        if (roll == 8)
            return own_ip_cfg;
        return own_ip_cfg | ~mask_cfg;
    endfunction

    function automatic arp_req_t random_request();
        arp_req_t r;
        int       roll;
        r.mode     = ($urandom_range(0, 1) == 0) ? MODE_RX_HEADER : MODE_RESOLVE;
        r.complete = 1'b1;
        r.htype    = HTYPE_ETH;
        r.ptype    = PTYPE_IPV4;
        r.mac      = {16'($urandom), $urandom};
        r.ip       = pick_ip();
        roll       = $urandom_range(0, 9);
        if (r.mode == MODE_RESOLVE)
        begin
            // fields a resolve ignores still toggle
            r.complete = 1'($urandom_range(0, 1));
            r.htype    = 16'($urandom);
            r.ptype    = 16'($urandom);
            r.op       = 16'($urandom);
            r.tip      = $urandom;
            if (roll == 0)
                r.ip = IP_ALL_ONES;
        end
        else
        begin
            r.op  = (roll < 4) ? OP_REQUEST : (roll < 7) ? OP_REPLY : 16'($urandom);
            r.tip = ($urandom_range(0, 1) == 0) ? own_ip_cfg : pick_ip();
            // break about one header in five
            case ($urandom_range(0, 14))
                0:       r.complete = 1'b0;
                1:       r.htype    = 16'($urandom);
                2:       r.ptype    = 16'($urandom);
                default: ;
            endcase
        end
        return r;
    endfunction

    // Called and returns at a falling edge.
    task automatic write_reg(input logic idx, input logic [31:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_config(input logic [31:0] own, input logic [31:0] mask);
        write_reg(REG_OWN_IP, own);
        write_reg(REG_NETMASK, mask);
        own_ip_cfg = own;
        mask_cfg   = mask;
    endtask

    // Called and returns at a falling edge; valid stays high into the next request.
    task automatic send_request(input arp_req_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                req_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        mode            = r.mode;
        header_complete = r.complete;
        hw_type         = r.htype;
        proto_type      = r.ptype;
        operation       = r.op;
        ip_address      = r.ip;
        sender_mac      = r.mac;
        target_addr     = r.tip;
        req_valid       = 1'b1;
        do @(posedge clk); while (req_stall);
        @(negedge clk);
    endtask

    // Drop valid and hold until every response is back and the engine is quiet.
    task automatic settle();
        req_valid = 1'b0;
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Response side: random stall segments, plus one long hold-off on request.
    initial
    begin
        rsp_flow_t flow;
        int        seg_len;
        bit        squeezed;
        rsp_stall = 1'b0;
        squeezed  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (squeeze_rsp && !squeezed)
            begin
                @(negedge clk);
                rsp_stall = 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                rsp_stall = 1'b0;
                squeezed  = 1'b1;
            end
            flow    = rsp_flow_t'($urandom_range(0, 3));
            seg_len = $urandom_range(5, 60);
            repeat (seg_len)
            begin
                @(negedge clk);
                case (flow)
                    FLOW_FREE:  rsp_stall = 1'b0;
                    FLOW_HALF:  rsp_stall = 1'($urandom_range(0, 1));
                    FLOW_HEAVY: rsp_stall = ($urandom_range(0, 3) != 0);
                    default:    rsp_stall = ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = REG_OWN_IP;
        cfg_data        = '0;
        req_valid       = 1'b0;
        mode            = MODE_RX_HEADER;
        header_complete = 1'b0;
        hw_type         = '0;
        proto_type      = '0;
        operation       = '0;
        ip_address      = '0;
        sender_mac      = '0;
        target_addr     = '0;
        own_ip_cfg      = '0;
        mask_cfg        = '0;
        for (int i = 0; i < POOL_SIZE; i++)
            ip_pool[i] = $urandom;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_config(32'hC0A8_0114, 32'hFFFF_FF00);

        // empty table: miss, limited and subnet broadcast
        send_request(make_request(MODE_RESOLVE, 1'b0, '0, '0, '0, 32'hC0A8_0133, '0, '0));
        send_request(make_request(MODE_RESOLVE, 1'b1, '0, '0, '0, IP_ALL_ONES, '0, '0));
        send_request(make_request(MODE_RESOLVE, 1'b0, '0, '0, '0, 32'hC0A8_01FF, '0, '0));
        // malformed headers
        send_request(make_request(MODE_RX_HEADER, 1'b0, HTYPE_ETH, PTYPE_IPV4, OP_REQUEST,
                                  32'h0A00_0007, 48'h0200_0000_0007, own_ip_cfg));
        send_request(make_request(MODE_RX_HEADER, 1'b1, 16'h0000, PTYPE_IPV4, OP_REQUEST,
                                  32'h0A00_0007, 48'h0200_0000_0007, own_ip_cfg));
        send_request(make_request(MODE_RX_HEADER, 1'b1, 16'hFFFF, PTYPE_IPV4, OP_REQUEST,
                                  32'h0A00_0007, 48'h0200_0000_0007, own_ip_cfg));
        send_request(make_request(MODE_RX_HEADER, 1'b1, HTYPE_ETH, 16'h0000, OP_REQUEST,
                                  32'h0A00_0007, 48'h0200_0000_0007, own_ip_cfg));
        send_request(make_request(MODE_RX_HEADER, 1'b1, HTYPE_ETH, 16'hFFFF, OP_REQUEST,
                                  32'h0A00_0007, 48'h0200_0000_0007, own_ip_cfg));
        // learn: zero fields, request to us, all-ones fields, request elsewhere, opcode 0
        send_request(make_request(MODE_RX_HEADER, 1'b1, HTYPE_ETH, PTYPE_IPV4, OP_REPLY,
                                  '0, '0, '0));
        send_request(make_request(MODE_RX_HEADER, 1'b1, HTYPE_ETH, PTYPE_IPV4, OP_REQUEST,
                                  32'hC0A8_0133, 48'h0011_2233_4455, own_ip_cfg));
        send_request(make_request(MODE_RX_HEADER, 1'b1, HTYPE_ETH, PTYPE_IPV4, 16'hFFFF,
                                  IP_ALL_ONES, MAC_ALL_ONES, IP_ALL_ONES));
        send_request(make_request(MODE_RX_HEADER, 1'b1, HTYPE_ETH, PTYPE_IPV4, OP_REQUEST,
                                  32'h0A00_0005, 48'h0200_0000_0005, 32'h0A00_0001));
        send_request(make_request(MODE_RX_HEADER, 1'b1, HTYPE_ETH, PTYPE_IPV4, 16'h0000,
                                  32'h0A00_0009, 48'h0200_0000_0009, own_ip_cfg));
        // hits, then overwrite an existing binding, then further hits and misses
        send_request(make_request(MODE_RESOLVE, 1'b0, '0, '0, '0, 32'hC0A8_0133, '0, '0));
        send_request(make_request(MODE_RESOLVE, 1'b0, '0, '0, '0, '0, '0, '0));
        send_request(make_request(MODE_RX_HEADER, 1'b1, HTYPE_ETH, PTYPE_IPV4, OP_REQUEST,
                                  32'hC0A8_0133, 48'hA0B0_C0D0_E0F0, own_ip_cfg));
        send_request(make_request(MODE_RESOLVE, 1'b0, '0, '0, '0, 32'hC0A8_0133, '0, '0));
        send_request(make_request(MODE_RESOLVE, 1'b0, '0, '0, '0, 32'h0A00_0006, '0, '0));
        send_request(make_request(MODE_RESOLVE, 1'b0, '0, '0, '0, own_ip_cfg, '0, '0));
        send_request(make_request(MODE_RESOLVE, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                  32'h0A00_0005, MAC_ALL_ONES, IP_ALL_ONES));

        for (int p = 0; p < PHASES; p++)
        begin
            if (p != 0)
            begin
                settle();
                case (p)
                    1:       set_config(IP_ALL_ONES, 32'hFFFF_FFFF);
                    2:       set_config(32'h0000_0000, 32'h0000_0000);
                    3:       set_config(32'h0A00_0001, 32'hFF00_0000);
                    default: set_config($urandom, $urandom);
                endcase
            end
            else
                squeeze_rsp = 1'b1;
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
                send_request(random_request());
        end

        settle();
        if (mismatches == 0 && outstanding == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

FILE: files.f
hdl/acache_pkg.sv
hdl/acache_ram.sv
hdl/arp_cache_engine_unit.sv
hdl/acache_check.sv
bench/acache_checker.sv
bench/tb_top.sv
